/* design/rfor_pkg.sv */
// ----------------------------------------------------------------------------
// rfor_pkg
// Shared types and constants for the rectangle fill/outline rasterizer.
// ----------------------------------------------------------------------------
package rfor_pkg;

  // Canvas geometry and coordinate format
  localparam int MAX_SIDE  = 256;
  localparam int FRAC_BITS = 8;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int DIM_W     = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int FIELD_W   = 24;
  // room for left + span without overflow
  localparam int COORD_W   = FIELD_W + 2;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(2 ** FRAC_BITS);

  // Rectangle type bytes
  localparam logic [CHAR_W-1:0] TYPE_FILL    = 8'h52;  // 'R'
  localparam logic [CHAR_W-1:0] TYPE_OUTLINE = 8'h72;  // 'r'

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]  RST_SIDE = DIM_W'(MAX_SIDE);
  localparam logic [CHAR_W-1:0] RST_BG   = 8'h20;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [CHAR_W-1:0]         rect_type;
    logic signed [FIELD_W-1:0] rect_left;
    logic signed [FIELD_W-1:0] rect_top;
    logic signed [FIELD_W-1:0] rect_span_x;
    logic signed [FIELD_W-1:0] rect_span_y;
    logic [CHAR_W-1:0]         paint_char;
    logic [7:0]                read_col;
    logic [7:0]                read_row;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [CHAR_W-1:0] pixel_value;
  } out_item_t;

  // Per-axis bounds: closed span [lo, hi], interior the closed range [lo_in, hi_in]
  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] lo_in;
    logic signed [COORD_W-1:0] hi_in;
    logic signed [COORD_W-1:0] hi;
  } axis_bounds_t;

  typedef struct packed {
    logic covered;
    logic near_edge;
  } axis_hit_t;

endpackage

/* design/rect_fill_outline_raster.sv */
// Throughput: one item at a time; the canvas sweep visits one pixel per cycle and
//   writes through the single write port of the canvas memory.
// Reset: size registers go to MAX_SIDE and background to a space; the canvas
//   memory is not cleared and holds garbage until a clear or a draw writes it.
// ----------------------------------------------------------------------------
// rect_fill_outline_raster
// Byte-per-pixel canvas with rectangle fill/outline drawing, clear and read.
// ----------------------------------------------------------------------------
module rect_fill_outline_raster (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rfor_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rfor_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rfor_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rfor_pkg::CFG_W-1:0]     cfg_data_i
);
  import rfor_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_side(logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > CFG_W'(MAX_SIDE)) begin
      r = DIM_W'(MAX_SIDE);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [CHAR_W-1:0] bg_q;

  in_item_t                  cmd_q;
  logic                      reject_q, filled_q, clear_q;
  logic signed [COORD_W-1:0] span_m1_x_q, span_m1_y_q;
  axis_bounds_t              bounds_x_q, bounds_y_q;
  logic [SIDE_W-1:0]         col_q, row_q, col_last_q, row_last_q;
  logic [CHAR_W-1:0]         rdata_q;
  logic                      rd_ok_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic                      accept, reject_d, load_out, sweep_end, paint;
  logic                      mem_we, mem_re;
  logic [CHAR_W-1:0]         mem_wdata;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic signed [COORD_W-1:0] left_ext, top_ext;
  axis_hit_t                 hit_x, hit_y;
  out_item_t                 res;

  logic [CHAR_W-1:0] canvas_mem [DEPTH];

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_SIDE;
      height_q <= RST_SIDE;
      bg_q     <= RST_BG;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= clamp_side(cfg_data_i);
        CFG_HEIGHT: height_q <= clamp_side(cfg_data_i);
        CFG_BG:     bg_q     <= cfg_data_i[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Draw validity check on the incoming beat
  assign reject_d = (in_data_i.rect_span_x <= 0) || (in_data_i.rect_span_y <= 0) ||
                    ((in_data_i.rect_type != TYPE_FILL) &&
                     (in_data_i.rect_type != TYPE_OUTLINE));

  // Pixel coverage per axis
  rfor_axis_test u_axis_x (
    .coord_i  (col_q),
    .bounds_i (bounds_x_q),
    .hit_o    (hit_x)
  );

  rfor_axis_test u_axis_y (
    .coord_i  (row_q),
    .bounds_i (bounds_y_q),
    .hit_o    (hit_y)
  );

  assign paint     = hit_x.covered && hit_y.covered &&
                     (hit_x.near_edge || hit_y.near_edge || filled_q);
  assign sweep_end = (col_q == col_last_q) && (row_q == row_last_q);

  // Result assembled from the finished command
  always_comb begin
    res.status      = (kind_e'(cmd_q.kind) == KIND_DRAW) && reject_q;
    res.pixel_value = ((kind_e'(cmd_q.kind) == KIND_READ) && rd_ok_q) ? rdata_q : '0;
  end

  // Control FSM: next state and strobes
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept = 1'b1;
          case (kind_e'(in_data_i.kind))
            KIND_DRAW:  state_d = reject_d ? ST_FINISH : ST_SETUP;
            KIND_READ:  state_d = ST_READ;
            KIND_CLEAR: state_d = ST_SWEEP;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        mem_we = clear_q || paint;
        if (sweep_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command capture and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (accept) begin
      clear_q <= (kind_e'(in_data_i.kind) == KIND_CLEAR);
      col_q   <= '0;
      row_q   <= '0;
    end else if (state_q == ST_SWEEP && !sweep_end) begin
      if (col_q == col_last_q) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= in_data_i;
      reject_q    <= reject_d;
      filled_q    <= (in_data_i.rect_type == TYPE_FILL);
      span_m1_x_q <= COORD_W'(in_data_i.rect_span_x) - ONE;
      span_m1_y_q <= COORD_W'(in_data_i.rect_span_y) - ONE;
      if (kind_e'(in_data_i.kind) == KIND_CLEAR) begin
        col_last_q <= '1;
        row_last_q <= '1;
      end else begin
        col_last_q <= SIDE_W'(width_q - 1'b1);
        row_last_q <= SIDE_W'(height_q - 1'b1);
      end
    end
  end

  // Rectangle bounds, registered in the setup state after accept
  assign left_ext = COORD_W'(cmd_q.rect_left);
  assign top_ext  = COORD_W'(cmd_q.rect_top);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      bounds_x_q.lo    <= left_ext;
      bounds_x_q.lo_in <= left_ext + ONE;
      bounds_x_q.hi_in <= left_ext + span_m1_x_q;
      bounds_x_q.hi    <= left_ext + COORD_W'(cmd_q.rect_span_x);
      bounds_y_q.lo    <= top_ext;
      bounds_y_q.lo_in <= top_ext + ONE;
      bounds_y_q.hi_in <= top_ext + span_m1_y_q;
      bounds_y_q.hi    <= top_ext + COORD_W'(cmd_q.rect_span_y);
    end
  end

  // Canvas memory: one write port, one registered read port
  assign mem_waddr = {row_q, col_q};
  assign mem_wdata = clear_q ? bg_q : cmd_q.paint_char;
  assign mem_raddr = {SIDE_W'(cmd_q.read_row), SIDE_W'(cmd_q.read_col)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= canvas_mem[mem_raddr];
      rd_ok_q <= (DIM_W'(cmd_q.read_col) < width_q) && (DIM_W'(cmd_q.read_row) < height_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/rfor_axis_test.sv */
// ----------------------------------------------------------------------------
// rfor_axis_test
// Tests one pixel coordinate against one axis of the rectangle.
// ----------------------------------------------------------------------------
module rfor_axis_test (
  input  logic [rfor_pkg::SIDE_W-1:0] coord_i,
  input  rfor_pkg::axis_bounds_t      bounds_i,
  output rfor_pkg::axis_hit_t         hit_o
);
  import rfor_pkg::*;

  logic signed [COORD_W-1:0] pos;

  // pixel center in fixed point
  assign pos = COORD_W'(coord_i) << FRAC_BITS;

  // within the closed span; near an edge when less than one unit from either end
  assign hit_o.covered   = (pos >= bounds_i.lo) && (pos <= bounds_i.hi);
  assign hit_o.near_edge = (pos < bounds_i.lo_in) || (pos > bounds_i.hi_in);

endmodule

/* design/rfor_checker.sv */
// ----------------------------------------------------------------------------
// rfor_checker
// Port-level checks for the rasterizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rfor_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input rfor_pkg::in_item_t             in_data_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input rfor_pkg::out_item_t            out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [rfor_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [rfor_pkg::CFG_W-1:0]     cfg_data_i
);
  import rfor_pkg::*;

  logic       push, pop;
  logic [1:0] head_kind_q, next_kind_q;
  logic [1:0] count_q;

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  // kinds of accepted beats whose result has not left yet, oldest first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_kind_q <= '0;
      next_kind_q <= '0;
      count_q     <= '0;
    end else if (push && !pop) begin
      if (count_q == 2'd0) begin
        head_kind_q <= in_data_i.kind;
      end else begin
        next_kind_q <= in_data_i.kind;
      end
      count_q <= count_q + 2'd1;
    end else if (pop && !push) begin
      head_kind_q <= next_kind_q;
      count_q     <= count_q - 2'd1;
    end else if (push && pop) begin
      if (count_q == 2'd1) begin
        head_kind_q <= in_data_i.kind;
      end else begin
        head_kind_q <= next_kind_q;
        next_kind_q <= in_data_i.kind;
      end
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // only reads return pixel data
  a_pixel_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_e'(head_kind_q) != KIND_READ) |-> out_data_o.pixel_value == '0)
    else $error("nonzero pixel on a non-read result");

  // only draws can be rejected
  a_reject_only_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> kind_e'(head_kind_q) == KIND_DRAW)
    else $error("reject status on a non-draw result");

endmodule

bind rect_fill_outline_raster rfor_checker u_rfor_checker (.*);

/* dv/rect_fill_outline_raster_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_fill_outline_raster_checker
// Watches the command, result and register channels of the rasterizer, keeps
// its own copy of the canvas and settings, and compares every result beat
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rect_fill_outline_raster_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  rfor_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  rfor_pkg::out_item_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rfor_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rfor_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             mismatch_count_o,
  output int                             pending_count_o
);
  import rfor_pkg::*;

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  // Shadow settings and canvas
  logic [DIM_W-1:0]  cols_in_use;
  logic [DIM_W-1:0]  rows_in_use;
  logic [CHAR_W-1:0] bg_char;
  logic [CHAR_W-1:0] canvas_mem [DEPTH];

  // Predicted result beats, oldest first
  out_item_t awaited_results_q[$];

  function automatic longint widen(input logic [FIELD_W-1:0] v);
    return {{(64-FIELD_W){v[FIELD_W-1]}}, v};
  endfunction

  // Out-of-range sizes saturate to 1..MAX_SIDE
  function automatic logic [DIM_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > CFG_W'(MAX_SIDE)) return DIM_W'(MAX_SIDE);
    return v[DIM_W-1:0];
  endfunction

  // Applies one command to the shadow canvas and returns its result beat
  function automatic out_item_t rasterize(input in_item_t cmd);
    out_item_t res;
    longint    left, top, right, bottom, px, py;
    logic      near_edge;
    res = '0;
    case (cmd.kind)
      KIND_DRAW: begin
        left   = widen(cmd.rect_left);
        top    = widen(cmd.rect_top);
        right  = left + widen(cmd.rect_span_x);
        bottom = top + widen(cmd.rect_span_y);
        if (widen(cmd.rect_span_x) <= 0 || widen(cmd.rect_span_y) <= 0 ||
            (cmd.rect_type != TYPE_FILL && cmd.rect_type != TYPE_OUTLINE)) begin
          res.status = 1'b1;
        end else begin
          for (int row = 0; row < int'(rows_in_use); row++) begin
            py = row * UNIT;
            for (int col = 0; col < int'(cols_in_use); col++) begin
              px = col * UNIT;
              if (px >= left && px <= right && py >= top && py <= bottom) begin
                // outline keeps only pixels less than one unit from an edge
                near_edge = (px - left < UNIT) || (right - px < UNIT) ||
                            (py - top < UNIT) || (bottom - py < UNIT);
                if (near_edge || cmd.rect_type == TYPE_FILL) begin
                  canvas_mem[row * MAX_SIDE + col] = cmd.paint_char;
                end
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (DIM_W'(cmd.read_col) < cols_in_use && DIM_W'(cmd.read_row) < rows_in_use) begin
          res.pixel_value = canvas_mem[int'(cmd.read_row) * MAX_SIDE + int'(cmd.read_col)];
        end
      end
      KIND_CLEAR: begin
        // whole store, not just the size in use
        for (int i = 0; i < DEPTH; i++) canvas_mem[i] = bg_char;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    if (!rst_ni) begin
      cols_in_use = RST_SIDE;
      rows_in_use = RST_SIDE;
      bg_char     = RST_BG;
      awaited_results_q.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  cols_in_use = clamp_side(cfg_data_i);
          CFG_HEIGHT: rows_in_use = clamp_side(cfg_data_i);
          CFG_BG:     bg_char = cfg_data_i[CHAR_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result beat, status %0d pixel %02h",
                   $time, out_data_i.status, out_data_i.pixel_value);
        end else begin
          want = awaited_results_q.pop_front();
          if (out_data_i.status !== want.status) begin
            mismatch_count_o++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data_i.status);
          end
          if (out_data_i.pixel_value !== want.pixel_value) begin
            mismatch_count_o++;
            $display("%0t: pixel_value mismatch, expected %02h, actual %02h",
                     $time, want.pixel_value, out_data_i.pixel_value);
          end
        end
      end

      // command beat
      if (in_valid_i && !in_stall_i) begin
        awaited_results_q.push_back(rasterize(in_data_i));
      end
    end
    pending_count_o = awaited_results_q.size();
  end

endmodule

/* dv/rect_fill_outline_raster_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_fill_outline_raster_tb
// Drives draw, read, clear and unused commands into the rasterizer under
// several canvas settings and handshake patterns; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module rect_fill_outline_raster_tb;
  import rfor_pkg::*;

  localparam int                   CLK_HALF      = 6;
  localparam int                   RESET_CYCLES  = 11;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   QUIET_LIMIT   = 300000;
  localparam int                   UNIT          = 1 << FRAC_BITS;
  localparam logic [1:0]           KIND_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_toggle    = 1'b0;
  bit hold_seen      = 1'b0;
  int hold_left      = 0;
  int canvas_cols    = MAX_SIDE;
  int canvas_rows    = MAX_SIDE;
  int mismatches;
  int pending;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  rect_fill_outline_raster DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rect_fill_outline_raster_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // Result side: random stalls, or a long hold-off when the toggle flips
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Ends the run when no channel moves a beat for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Random content in every field; commands override what they use
  function automatic in_item_t random_fill();
    logic [31:0] a, b, c, d, e;
    in_item_t    item;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    d = $urandom;
    e = $urandom;
    item.kind        = a[25:24];
    item.rect_left   = a[23:0];
    item.rect_top    = b[23:0];
    item.rect_span_x = c[23:0];
    item.rect_span_y = d[23:0];
    item.rect_type   = e[7:0];
    item.paint_char  = e[15:8];
    item.read_col    = e[23:16];
    item.read_row    = e[31:24];
    return item;
  endfunction

  function automatic in_item_t draw_cmd(input logic [7:0] rtype, input int l, input int t,
                                        input int w, input int h, input logic [7:0] paint);
    in_item_t item;
    item             = random_fill();
    item.kind        = KIND_DRAW;
    item.rect_type   = rtype;
    item.rect_left   = l[23:0];
    item.rect_top    = t[23:0];
    item.rect_span_x = w[23:0];
    item.rect_span_y = h[23:0];
    item.paint_char  = paint;
    return item;
  endfunction

  function automatic in_item_t read_cmd(input int col, input int row);
    in_item_t item;
    item          = random_fill();
    item.kind     = KIND_READ;
    item.read_col = col[7:0];
    item.read_row = row[7:0];
    return item;
  endfunction

  function automatic in_item_t bare_cmd(input logic [1:0] kind);
    in_item_t item;
    item      = random_fill();
    item.kind = kind;
    return item;
  endfunction

  // Mostly well-formed draws around the canvas, plus reads and some noise
  function automatic in_item_t random_item();
    in_item_t item;
    int       sel, reach_x, reach_y, v, lim;
    item    = random_fill();
    sel     = $urandom_range(99);
    reach_x = (canvas_cols + 4) * UNIT;
    reach_y = (canvas_rows + 4) * UNIT;
    if (sel < 8) begin
      // raw fields; no clear here, each one sweeps the whole store
      if (item.kind == KIND_CLEAR) item.kind = KIND_UNUSED;
    end else if (sel < 40) begin
      item.kind = KIND_READ;
      if ($urandom_range(3) != 0) begin
        lim = (canvas_cols + 2 > 255) ? 255 : canvas_cols + 2;
        item.read_col = 8'($urandom_range(lim));
        lim = (canvas_rows + 2 > 255) ? 255 : canvas_rows + 2;
        item.read_row = 8'($urandom_range(lim));
      end
    end else if (sel < 45) begin
      item.kind = KIND_UNUSED;
    end else begin
      item.kind = KIND_DRAW;
      v = $urandom_range(9);
      if (v >= 1 && v <= 4) item.rect_type = TYPE_FILL;
      else if (v >= 5) item.rect_type = TYPE_OUTLINE;
      v = $urandom_range(reach_x) - 2 * UNIT;
      item.rect_left = v[23:0];
      v = $urandom_range(reach_y) - 2 * UNIT;
      item.rect_top = v[23:0];
      v = ($urandom_range(19) == 0) ? -$urandom_range(UNIT) : $urandom_range(1, reach_x);
      item.rect_span_x = v[23:0];
      v = ($urandom_range(19) == 0) ? -$urandom_range(UNIT) : $urandom_range(1, reach_y);
      item.rect_span_y = v[23:0];
    end
    return item;
  endfunction

  // One command beat; returns at the edge that took it
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic resize(input int cols, input int rows);
    set_reg(CFG_WIDTH, CFG_W'(cols));
    set_reg(CFG_HEIGHT, CFG_W'(rows));
    canvas_cols = (cols == 0) ? 1 : (cols > MAX_SIDE) ? MAX_SIDE : cols;
    canvas_rows = (rows == 0) ? 1 : (rows > MAX_SIDE) ? MAX_SIDE : rows;
  endtask

  // Sender pauses until every predicted beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles a little, receiver a lot
    send_idle_pct  = 14;
    recv_stall_pct <= 70;
    resize(20, 15);
    set_reg(CFG_BG, 9'h12E);

    // directed: clear first so no read hits an unwritten pixel
    send_item(bare_cmd(KIND_CLEAR));
    send_item(read_cmd(0, 0));
    send_item(read_cmd(19, 14));
    send_item(read_cmd(20, 0));
    send_item(read_cmd(255, 255));
    // fill covering the whole canvas, then an outline whose edges lie outside
    send_item(draw_cmd(TYPE_FILL, -128, -128, 8388607, 8388607, 8'h43));
    send_item(draw_cmd(TYPE_OUTLINE, -256, -256, 8388607, 8388607, 8'h44));
    // extreme corners, nothing lands on the canvas
    send_item(draw_cmd(TYPE_FILL, -8388608, -8388608, 8388607, 8388607, 8'hFF));
    send_item(draw_cmd(TYPE_OUTLINE, 8388607, 8388607, 8388607, 8388607, 8'h00));
    // fractional bounds
    send_item(draw_cmd(TYPE_FILL, 'h280, 'h100, 'h500, 'h3C0, 8'h41));
    send_item(draw_cmd(TYPE_OUTLINE, -128, -128, 'hA40, 'h880, 8'h42));
    // smallest span on an integer point
    send_item(draw_cmd(TYPE_FILL, 3 * UNIT, 3 * UNIT, 1, 1, 8'h5A));
    // rejected draws
    send_item(draw_cmd(TYPE_FILL, 0, 0, 0, UNIT, 8'h11));
    send_item(draw_cmd(TYPE_OUTLINE, 0, 0, UNIT, -1, 8'h12));
    send_item(draw_cmd(TYPE_FILL, 0, 0, -8388608, UNIT, 8'h13));
    send_item(draw_cmd(8'h00, 0, 0, UNIT, UNIT, 8'h14));
    send_item(draw_cmd(8'hFF, 0, 0, UNIT, UNIT, 8'h15));
    send_item(bare_cmd(KIND_UNUSED));
    send_item(read_cmd(3, 1));
    send_item(read_cmd(7, 4));
    send_item(read_cmd(9, 7));
    send_item(read_cmd(3, 3));
    send_item(read_cmd(5, 5));

    repeat (10) send_item(random_item());
    wait_drained();

    // size extremes: zero saturates up, oversize saturates down
    resize(0, 511);
    set_reg(CFG_BG, 9'h000);
    set_reg(CFG_UNUSED, 9'h1FF);
    repeat (8) send_item(random_item());
    wait_drained();
    resize(300, 0);
    set_reg(CFG_BG, 9'h1FF);
    repeat (8) send_item(random_item());
    wait_drained();

    // sender idles a lot, receiver a little
    send_idle_pct  = 70;
    recv_stall_pct <= 14;
    resize($urandom_range(1, 32), $urandom_range(1, 32));
    set_reg(CFG_BG, CFG_W'($urandom_range(511)));
    send_item(bare_cmd(KIND_CLEAR));
    repeat (30) send_item(random_item());
    wait_drained();

    // no idling; full-size canvas for a few draws
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    resize(MAX_SIDE, MAX_SIDE);
    send_item(draw_cmd(TYPE_OUTLINE, -128, 3 * UNIT + 17, 200 * UNIT + 5, 250 * UNIT,
                       8'($urandom)));
    send_item(draw_cmd(TYPE_FILL, 100 * UNIT + 128, -5 * UNIT, 120 * UNIT, 300 * UNIT,
                       8'($urandom)));
    send_item(read_cmd(0, 3));
    send_item(read_cmd(99, 100));
    send_item(read_cmd(255, 255));
    wait_drained();

    // result side holds off while commands keep coming
    resize(8, 8);
    hold_toggle <= ~hold_toggle;
    repeat (8) send_item(random_item());
    repeat (30) send_item(random_item());
    wait_drained();

    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
